// File: design/scbp_pkg.sv
// Shared types and codes for the synth control byte parser.
`timescale 1ns / 1ps
`default_nettype none

package scbp_pkg;

	localparam int NUM_VOICES_DEF = 4;

	localparam int BYTE_W   = 8;
	localparam int DATA_W   = 7;
	localparam int MOD_W    = 3;
	localparam int PARAM_W  = 4;
	localparam int TGT_W    = 5;
	localparam int VOICE_W  = 2;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA1,
		PH_DATA2,
		PH_DATA3
	} phase_t;

	// module codes from the header
	localparam logic [MOD_W-1:0] MOD_OSC = 3'd0;
	localparam logic [MOD_W-1:0] MOD_KBD = 3'd1;
	localparam logic [MOD_W-1:0] MOD_LFO = 3'd2;
	localparam logic [MOD_W-1:0] MOD_ENV = 3'd3;
	localparam logic [MOD_W-1:0] MOD_FX  = 3'd4;
	localparam logic [MOD_W-1:0] MOD_EQ  = 3'd5;

	// parameter codes and highest valid parameter per module
	localparam logic [PARAM_W-1:0] KBD_KEY       = 4'd0;
	localparam logic [PARAM_W-1:0] KBD_OCTAVE    = 4'd1;
	localparam logic [PARAM_W-1:0] OSC_PARAM_MAX = 4'd3;
	localparam logic [PARAM_W-1:0] LFO_PARAM_MAX = 4'd2;
	localparam logic [PARAM_W-1:0] ENV_PARAM_MAX = 4'd3;
	localparam logic [PARAM_W-1:0] FX_PARAM_MAX  = 4'd2;

	// written-parameter targets
	localparam logic [TGT_W-1:0] TGT_OSC_BASE  = 5'd0;
	localparam logic [TGT_W-1:0] TGT_KEY       = 5'd4;
	localparam logic [TGT_W-1:0] TGT_GATE      = 5'd5;
	localparam logic [TGT_W-1:0] TGT_OCTAVE    = 5'd6;
	localparam logic [TGT_W-1:0] TGT_LFO_BASE  = 5'd7;
	localparam logic [TGT_W-1:0] TGT_ENV_BASE  = 5'd10;
	localparam logic [TGT_W-1:0] TGT_FX_BASE   = 5'd14;
	localparam logic [TGT_W-1:0] TGT_EQ_CENTRE = 5'd17;
	localparam logic [TGT_W-1:0] TGT_EQ_GAIN   = 5'd18;
	localparam logic [TGT_W-1:0] TGT_EQ_Q      = 5'd19;

	typedef struct packed {
		logic              en;
		logic [DATA_W-1:0] key;
	} key_req_t;

	typedef struct packed {
		logic [TGT_W-1:0]   target;
		logic [VOICE_W-1:0] voice;
		logic               all_voices;
		logic [PARAM_W-1:0] band;
		logic [DATA_W-1:0]  data_value;
		logic               eq_apply;
	} result_t;

endpackage

`default_nettype wire

// File: design/scbp_voice_alloc.sv
// Voice slot table: key match search and round-robin slot assignment.
`timescale 1ns / 1ps
`default_nettype none

module scbp_voice_alloc
	import scbp_pkg::*;
#(
	parameter int NUM_VOICES = NUM_VOICES_DEF,
	localparam int VW = $clog2(NUM_VOICES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire key_req_t      key_req,
	output logic      [VW-1:0] assign_voice,
	output logic      [VW-1:0] cur_voice
);

	logic [DATA_W-1:0] keys_q [NUM_VOICES];
	logic [VW-1:0]     cur_voice_q;
	logic [NUM_VOICES-1:0] match;
	logic [VW-1:0]     hit_idx;
	logic [VW-1:0]     next_idx;
	logic              found;

	always_comb begin
		for (int i = 0; i < NUM_VOICES; i++) begin
			match[i] = (keys_q[i] == key_req.key);
		end
	end

	// lowest matching slot wins
	always_comb begin
		hit_idx = '0;
		for (int i = NUM_VOICES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_idx = VW'(i);
			end
		end
	end

	assign found    = |match;
	assign next_idx = (cur_voice_q == VW'(NUM_VOICES - 1)) ? '0 : cur_voice_q + VW'(1);

	assign assign_voice = found ? hit_idx : next_idx;
	assign cur_voice    = cur_voice_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_voice_q <= '0;
			for (int i = 0; i < NUM_VOICES; i++) begin
				keys_q[i] <= '0;
			end
		end else if (key_req.en) begin
			cur_voice_q <= assign_voice;
			// claim the next slot on a miss
			if (!found) begin
				keys_q[next_idx] <= key_req.key;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/synth_control_byte_parser.sv
// Top level of the synth control byte parser: header decode, data phases, result register.
//
//  channel | dir | signals                    | request
//  --------+-----+----------------------------+------------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata  | one control byte
//  m_      | out | m_tvalid m_tready m_tdata  | one parameter write, target in m_tuser
//              |     |   m_tuser                  |
//
//  One byte is accepted per cycle while s_tready is high; its result is in the output register from the next cycle.
//  The phase register and the voice slot table are updated on the same clock edge that accepts the byte.
//  s_tready drops only while a held result waits on m_tready.
//  arst_n clears phase, header fields, voice keys and the round-robin pointer at once.
`timescale 1ns / 1ps
`default_nettype none

module synth_control_byte_parser
	import scbp_pkg::*;
#(
	parameter int NUM_VOICES = NUM_VOICES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] ctrl_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] voice, [2] all_voices, [6:3] band, [13:7] data_value, [14] eq_apply, [15] zero
	output logic      [15:0] m_tdata,
	output logic      [4:0]  m_tuser   // [4:0] target
);

	localparam int VW = $clog2(NUM_VOICES);

	phase_t             phase_q, phase_d;
	logic [MOD_W-1:0]   mod_q, mod_d;
	logic [PARAM_W-1:0] param_q, param_d;

	logic               s_accept;
	logic               is_header;
	logic [DATA_W-1:0]  data;
	key_req_t           key_req;
	logic [VW-1:0]      assign_voice;
	logic [VW-1:0]      cur_voice;

	result_t            res;
	logic               res_valid;
	result_t            res_q;
	logic               m_tvalid_q;

	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_accept  = s_tvalid && s_tready;
	assign is_header = s_tdata[BYTE_W-1];
	assign data      = s_tdata[DATA_W-1:0];

	assign key_req.en  = s_accept && !is_header && (phase_q == PH_DATA1) &&
	                     (mod_q == MOD_KBD) && (param_q == KBD_KEY);
	assign key_req.key = data;

	scbp_voice_alloc #(
		.NUM_VOICES (NUM_VOICES)
	) u_voice_alloc (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_req      (key_req),
		.assign_voice (assign_voice),
		.cur_voice    (cur_voice)
	);

	// next phase and header fields
	always_comb begin
		phase_d = phase_q;
		mod_d   = mod_q;
		param_d = param_q;
		if (phase_q == PH_IDLE) begin
			if (is_header) begin
				mod_d   = s_tdata[6:4];
				param_d = s_tdata[3:0];
				phase_d = PH_DATA1;
			end
		end else if (!is_header) begin
			case (mod_q)
				MOD_OSC, MOD_LFO, MOD_ENV, MOD_FX: begin
					phase_d = PH_IDLE;
				end
				MOD_KBD: begin
					if (param_q == KBD_KEY) begin
						phase_d = (phase_q == PH_DATA1) ? PH_DATA2 : PH_IDLE;
					end else if (param_q == KBD_OCTAVE) begin
						phase_d = PH_IDLE;
					end
					// other keyboard parameters hold data mode
				end
				MOD_EQ: begin
					case (phase_q)
						PH_DATA1: phase_d = PH_DATA2;
						PH_DATA2: phase_d = PH_DATA3;
						default:  phase_d = PH_IDLE;
					endcase
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// result fields
	always_comb begin
		res            = '0;
		res.data_value = data;
		res_valid      = 1'b0;
		if (phase_q != PH_IDLE && !is_header) begin
			case (mod_q)
				MOD_OSC: begin
					res_valid      = (param_q <= OSC_PARAM_MAX);
					res.target     = TGT_OSC_BASE + TGT_W'(param_q);
					res.all_voices = 1'b1;
				end
				MOD_KBD: begin
					if (param_q == KBD_KEY) begin
						if (phase_q == PH_DATA1) begin
							res_valid  = 1'b1;
							res.target = TGT_KEY;
							res.voice  = VOICE_W'(assign_voice);
						end else if (phase_q == PH_DATA2) begin
							res_valid  = 1'b1;
							res.target = TGT_GATE;
							res.voice  = VOICE_W'(cur_voice);
						end
					end else if (param_q == KBD_OCTAVE) begin
						res_valid      = 1'b1;
						res.target     = TGT_OCTAVE;
						res.all_voices = 1'b1;
					end
				end
				MOD_LFO: begin
					res_valid  = (param_q <= LFO_PARAM_MAX);
					res.target = TGT_LFO_BASE + TGT_W'(param_q);
				end
				MOD_ENV: begin
					res_valid      = (param_q <= ENV_PARAM_MAX);
					res.target     = TGT_ENV_BASE + TGT_W'(param_q);
					res.all_voices = 1'b1;
				end
				MOD_FX: begin
					res_valid  = (param_q <= FX_PARAM_MAX);
					res.target = TGT_FX_BASE + TGT_W'(param_q);
				end
				MOD_EQ: begin
					res_valid = 1'b1;
					res.band  = param_q;
					case (phase_q)
						PH_DATA1: res.target = TGT_EQ_CENTRE;
						PH_DATA2: res.target = TGT_EQ_GAIN;
						default: begin
							res.target   = TGT_EQ_Q;
							res.eq_apply = 1'b1;
						end
					endcase
				end
				default: begin
					res_valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mod_q   <= '0;
			param_q <= '0;
		end else if (s_accept) begin
			phase_q <= phase_d;
			mod_q   <= mod_d;
			param_q <= param_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_accept) begin
			m_tvalid_q <= res_valid;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// hold payload until a new request overwrites it
	always_ff @(posedge clk) begin
		if (s_accept && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.target;
	assign m_tdata  = {1'b0, res_q.eq_apply, res_q.data_value, res_q.band,
	                   res_q.all_voices, res_q.voice};

endmodule

`default_nettype wire

// File: design/scbp_checker.sv
// Port-level assertions for the synth control byte parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module scbp_checker
	import scbp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [4:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// single result register: no new request while one is stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	// a fresh result needs a request accepted the cycle before
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("result without a request");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser <= TGT_EQ_Q)
		else $error("target out of range");

	a_apply_on_q: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tuser == TGT_EQ_Q && m_tdata[2:0] == 3'b000)
		else $error("recompute flag on a non-Q write");

endmodule

bind synth_control_byte_parser scbp_checker u_scbp_checker (.*);

`default_nettype wire

// File: bench/tb_synth_control_byte_parser.sv
// Self-checking testbench for the synth control byte parser, stream in, parameter writes out.
`timescale 1ns / 1ps

module tb_synth_control_byte_parser;
	import scbp_pkg::*;

	localparam int NUM_VOICES  = NUM_VOICES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int STALL_LEN   = 300;
	localparam int IDLE_PCT    = 27;

	// header modules the block does not decode; either one locks the parser in data mode
	localparam logic [MOD_W-1:0] MOD_RSVD6 = 3'd6;
	localparam logic [MOD_W-1:0] MOD_RSVD7 = 3'd7;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [15:0] m_tdata;
	logic [4:0]  m_tuser;

	synth_control_byte_parser #(
		.NUM_VOICES(NUM_VOICES)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser state as predicted by the bench
	phase_t             ph = PH_IDLE;
	logic [MOD_W-1:0]   cur_mod = '0;
	logic [PARAM_W-1:0] cur_par = '0;
	logic [DATA_W-1:0]  slot_keys [NUM_VOICES];
	int unsigned        rr_slot = 0;

	result_t pending_writes [$];
	int      n_bad      = 0;
	int      bytes_used = 0;
	int      cycle_cnt  = 0;
	bit      send_idle  = 1'b1;
	bit      recv_idle  = 1'b1;
	int      stall_asks = 0;

	initial begin
		for (int i = 0; i < NUM_VOICES; i++)
			slot_keys[i] = '0;
	end

	// Work out the parameter write that one accepted byte causes, if any.
	task automatic decode_ctrl_byte(input logic [7:0] b);
		result_t           w;
		logic              hit;
		logic              found;
		logic [DATA_W-1:0] d;
		d = b[6:0];
		w = '0;
		hit = 1'b0;
		found = 1'b0;
		if (ph == PH_IDLE) begin
			if (b[7]) begin
				cur_mod = b[6:4];
				cur_par = b[3:0];
				ph = PH_DATA1;
				bytes_used++;
			end
		end else if (!b[7]) begin
			bytes_used++;
			w.data_value = d;
			case (cur_mod)
				MOD_OSC: begin
					ph = PH_IDLE;
					if (cur_par <= OSC_PARAM_MAX) begin
						hit = 1'b1;
						w.target = TGT_OSC_BASE + TGT_W'(cur_par);
						w.all_voices = 1'b1;
					end
				end
				MOD_KBD: begin
					if (cur_par == KBD_KEY) begin
						if (ph == PH_DATA1) begin
							for (int i = 0; i < NUM_VOICES; i++) begin
								if (!found && slot_keys[i] == d) begin
									rr_slot = i;
									found = 1'b1;
								end
							end
							if (!found) begin
								rr_slot = (rr_slot + 1) % NUM_VOICES;
								slot_keys[rr_slot] = d;
							end
							ph = PH_DATA2;
							hit = 1'b1;
							w.target = TGT_KEY;
							w.voice = rr_slot[VOICE_W-1:0];
						end else if (ph == PH_DATA2) begin
							ph = PH_IDLE;
							hit = 1'b1;
							w.target = TGT_GATE;
							w.voice = rr_slot[VOICE_W-1:0];
						end else begin
							ph = PH_IDLE;
						end
					end else if (cur_par == KBD_OCTAVE) begin
						ph = PH_IDLE;
						hit = 1'b1;
						w.target = TGT_OCTAVE;
						w.all_voices = 1'b1;
					end
					// any other keyboard parameter: stay in data mode for good
				end
				MOD_LFO: begin
					ph = PH_IDLE;
					if (cur_par <= LFO_PARAM_MAX) begin
						hit = 1'b1;
						w.target = TGT_LFO_BASE + TGT_W'(cur_par);
					end
				end
				MOD_ENV: begin
					ph = PH_IDLE;
					if (cur_par <= ENV_PARAM_MAX) begin
						hit = 1'b1;
						w.target = TGT_ENV_BASE + TGT_W'(cur_par);
						w.all_voices = 1'b1;
					end
				end
				MOD_FX: begin
					ph = PH_IDLE;
					if (cur_par <= FX_PARAM_MAX) begin
						hit = 1'b1;
						w.target = TGT_FX_BASE + TGT_W'(cur_par);
					end
				end
				MOD_EQ: begin
					hit = 1'b1;
					w.band = cur_par;
					if (ph == PH_DATA1) begin
						ph = PH_DATA2;
						w.target = TGT_EQ_CENTRE;
					end else if (ph == PH_DATA2) begin
						ph = PH_DATA3;
						w.target = TGT_EQ_GAIN;
					end else begin
						ph = PH_IDLE;
						w.target = TGT_EQ_Q;
						w.eq_apply = 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (hit)
			pending_writes.push_back(w);
	endtask

	// Offer one byte and hold it until the block takes it.
	task automatic push_byte(input logic [7:0] b);
		@(negedge clk);
		while (send_idle && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		decode_ctrl_byte(b);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] hdr(input logic [MOD_W-1:0] md, input logic [PARAM_W-1:0] pr);
		return {1'b1, md, pr};
	endfunction

	// Mostly a valid parameter, now and then any of the sixteen.
	function automatic logic [PARAM_W-1:0] pick_param(input logic [PARAM_W-1:0] pmax);
		if ($urandom_range(99) < 85)
			return PARAM_W'($urandom_range(pmax));
		return PARAM_W'($urandom_range(15));
	endfunction

	// Random byte that can never open a locking message.
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (ph == PH_IDLE && b[7] && (b[6:4] == MOD_RSVD6 || b[6:4] == MOD_RSVD7 ||
				(b[6:4] == MOD_KBD && b[3:0] != KBD_KEY && b[3:0] != KBD_OCTAVE)))
			b[7] = 1'b0;
		return b;
	endfunction

	// One header and its data bytes with random content; optionally cut short or padded.
	task automatic send_message(input bit allow_broken);
		logic [MOD_W-1:0]   md;
		logic [PARAM_W-1:0] pr;
		logic [DATA_W-1:0]  d;
		int                 n;
		md = MOD_W'($urandom_range(5));
		case (md)
			MOD_OSC: pr = pick_param(OSC_PARAM_MAX);
			MOD_KBD: pr = $urandom_range(1) ? KBD_OCTAVE : KBD_KEY;
			MOD_LFO: pr = pick_param(LFO_PARAM_MAX);
			MOD_ENV: pr = pick_param(ENV_PARAM_MAX);
			MOD_FX:  pr = pick_param(FX_PARAM_MAX);
			default: pr = PARAM_W'($urandom_range(15));
		endcase
		if (md == MOD_EQ)
			n = 3;
		else if (md == MOD_KBD && pr == KBD_KEY)
			n = 2;
		else
			n = 1;
		if (allow_broken && $urandom_range(99) < 10)
			n = $urandom_range(3);
		if (allow_broken && $urandom_range(99) < 8)
			push_byte(noise_byte());
		push_byte(hdr(md, pr));
		for (int i = 0; i < n; i++) begin
			if (allow_broken && $urandom_range(99) < 5)
				push_byte(noise_byte());
			// small key pool so that slots get matched again
			if (md == MOD_KBD && pr == KBD_KEY && i == 0 && $urandom_range(99) < 70)
				d = DATA_W'($urandom_range(7));
			else
				d = DATA_W'($urandom_range(127));
			push_byte({1'b0, d});
		end
	endtask

	task automatic test_directed();
		// oscillator: lowest and highest parameter, then an unknown one
		push_byte(hdr(MOD_OSC, 4'd0));           push_byte(8'h00);
		push_byte(hdr(MOD_OSC, OSC_PARAM_MAX));  push_byte(8'h7F);
		push_byte(hdr(MOD_OSC, 4'd4));           push_byte(8'h55);
		// key 0 hits slot 0 out of reset; a header while busy is dropped
		push_byte(hdr(MOD_KBD, KBD_KEY));        push_byte(8'h00);
		push_byte(8'hFF);                        push_byte(8'h7F);
		push_byte(hdr(MOD_KBD, KBD_KEY));        push_byte(8'h7F);  push_byte(8'h00);
		push_byte(hdr(MOD_KBD, KBD_OCTAVE));     push_byte(8'h2A);
		push_byte(hdr(MOD_LFO, LFO_PARAM_MAX));  push_byte(8'h11);
		push_byte(hdr(MOD_LFO, 4'd3));           push_byte(8'h22);
		push_byte(hdr(MOD_ENV, ENV_PARAM_MAX));  push_byte(8'h33);
		push_byte(hdr(MOD_FX, FX_PARAM_MAX));    push_byte(8'h44);
		push_byte(hdr(MOD_EQ, 4'd15));
		push_byte(8'h01); push_byte(8'h40); push_byte(8'h7E);
		// data while idle is dropped
		push_byte(8'h00);
	endtask

	task automatic test_random_messages(input int count);
		int goal;
		goal = bytes_used + count;
		while (bytes_used < goal)
			send_message(1'b1);
	endtask

	task automatic test_back_pressure();
		int goal;
		send_idle = 1'b0;
		stall_asks++;
		goal = bytes_used + 150;
		while (bytes_used < goal)
			send_message(1'b0);
		send_idle = 1'b1;
	endtask

	task automatic test_no_idle();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		test_random_messages(250);
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	// Lock the parser in data mode; nothing may come out afterwards.
	task automatic test_lockup();
		while (ph != PH_IDLE)
			push_byte({1'b0, DATA_W'($urandom_range(127))});
		case ($urandom_range(2))
			0:       push_byte(hdr(MOD_RSVD6, PARAM_W'($urandom_range(15))));
			1:       push_byte(hdr(MOD_RSVD7, PARAM_W'($urandom_range(15))));
			default: push_byte(hdr(MOD_KBD, PARAM_W'($urandom_range(2, 15))));
		endcase
		for (int i = 0; i < 40; i++)
			push_byte(8'($urandom_range(255)));
	endtask

	// receiver: random idling, plus a long hold-off on request
	int stall_seen = 0;
	int hold_left  = 0;
	always @(negedge clk) begin
		if (stall_asks != stall_seen) begin
			stall_seen = stall_asks;
			hold_left = STALL_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= !recv_idle || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : chk
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_writes.size() == 0) begin
				$error("unexpected write: target %0d, tdata 0x%h", m_tuser, m_tdata);
				n_bad++;
			end else begin
				want = pending_writes.pop_front();
				if (m_tuser != want.target) begin
					$error("target: expected %0d, got %0d", want.target, m_tuser);
					n_bad++;
				end
				if (m_tdata[1:0] != want.voice) begin
					$error("voice: expected %0d, got %0d", want.voice, m_tdata[1:0]);
					n_bad++;
				end
				if (m_tdata[2] != want.all_voices) begin
					$error("all_voices: expected %0d, got %0d", want.all_voices, m_tdata[2]);
					n_bad++;
				end
				if (m_tdata[6:3] != want.band) begin
					$error("band: expected %0d, got %0d", want.band, m_tdata[6:3]);
					n_bad++;
				end
				if (m_tdata[13:7] != want.data_value) begin
					$error("data_value: expected %0d, got %0d", want.data_value, m_tdata[13:7]);
					n_bad++;
				end
				if (m_tdata[14] != want.eq_apply) begin
					$error("eq_apply: expected %0d, got %0d", want.eq_apply, m_tdata[14]);
					n_bad++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		wait_drained();
		test_random_messages(550);
		test_back_pressure();
		wait_drained();
		test_no_idle();
		test_lockup();
		wait_drained();
		repeat (8) @(posedge clk);
		if (n_bad == 0 && pending_writes.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: synth_control_byte_parser.f
design/scbp_pkg.sv
design/scbp_voice_alloc.sv
design/synth_control_byte_parser.sv
design/scbp_checker.sv
bench/tb_synth_control_byte_parser.sv
